FILE: src/fep_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the fast exp pipeline.
// No dependencies.
package fep_pkg;

   // single-precision constants as bit patterns
   localparam logic [31:0] FP_LOG2E = 32'h3FB8AA3B;
   localparam logic [31:0] FP_LN2   = 32'h3F317218;
   localparam logic [31:0] FP_CF4   = 32'h3D2D7D7D;
   localparam logic [31:0] FP_CF3   = 32'h3E2AF080;
   localparam logic [31:0] FP_CF2   = 32'h3EFFF205;
   localparam logic [31:0] FP_CF1   = 32'h3F80016A;
   localparam logic [31:0] FP_ONE   = 32'h3F800000;
   localparam logic [31:0] FP_HALF  = 32'h3F000000;
   localparam logic [31:0] FP_NHALF = 32'hBF000000;
   localparam logic [31:0] FP_QNAN  = 32'h7FC00000;
   localparam logic [31:0] FP_PINF  = 32'h7F800000;
   localparam logic [31:0] FP_PZERO = 32'h00000000;

   localparam int unsigned EXP_BIAS  = 127;
   localparam int unsigned MANT_BITS = 23;

   // pipeline depths
   localparam int unsigned OP_LAT    = 3;   // each add or multiply unit
   localparam int unsigned PIPE_LAT  = 41;  // input register to output register

   typedef enum logic [1:0] {
      SPC_NONE,
      SPC_ZERO,
      SPC_INF,
      SPC_NAN
   } spc_type;

   function automatic logic [5:0] clz48(input logic [47:0] v);
      logic [5:0] n;
      logic       hit;
      n   = 6'd48;
      hit = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!hit && v[i]) begin
            n   = 6'(47 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [4:0] clz28(input logic [27:0] v);
      logic [4:0] n;
      logic       hit;
      n   = 5'd28;
      hit = 1'b0;
      for (int i = 27; i >= 0; i--) begin
         if (!hit && v[i]) begin
            n   = 5'(27 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

FILE: src/fep_dly.sv
`timescale 1ns / 1ps
// Enabled shift line that delays a payload word by D stages.
// Depends on nothing.
module fep_dly #(
   parameter int unsigned W = 32,
   parameter int unsigned D = 3
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] pipe_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d;
         for (int i = 1; i < int'(D); i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign q = pipe_ff[D-1];

endmodule

FILE: src/fep_mul.sv
`timescale 1ns / 1ps
// Single-precision multiplier, round to nearest even, IEEE subnormals.
// Three stages: mantissa product, normalize, denormalize and round. Uses fep_pkg.
module fep_mul import fep_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);

   // stage A
   logic [7:0]         ea, eb, eae, ebe;
   logic [23:0]        ma, mb;
   logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   spc_type            spc_a_in, spc_a_ff;
   logic               sgn_a_ff;
   logic [47:0]        prod_a_in, prod_a_ff;
   logic signed [10:0] exp_a_in, exp_a_ff;

   always_comb begin
      ea     = a[30:23];
      eb     = b[30:23];
      eae    = (ea == 8'd0) ? 8'd1 : ea;
      ebe    = (eb == 8'd0) ? 8'd1 : eb;
      ma     = {|ea, a[22:0]};
      mb     = {|eb, b[22:0]};
      a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      priority if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
         spc_a_in = SPC_NAN;
      end else if (a_inf || b_inf) begin
         spc_a_in = SPC_INF;
      end else if (a_zero || b_zero) begin
         spc_a_in = SPC_ZERO;
      end else begin
         spc_a_in = SPC_NONE;
      end
      prod_a_in = {24'd0, ma} * {24'd0, mb};
      exp_a_in  = $signed({3'd0, eae}) + $signed({3'd0, ebe}) - 11'sd127;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spc_a_ff  <= spc_a_in;
         sgn_a_ff  <= a[31] ^ b[31];
         prod_a_ff <= prod_a_in;
         exp_a_ff  <= exp_a_in;
      end
   end

   // stage B: leading one to bit 47
   logic [5:0]         lz;
   logic [47:0]        norm_b_in, norm_b_ff;
   logic signed [10:0] exp_b_in, exp_b_ff;
   spc_type            spc_b_ff;
   logic               sgn_b_ff;

   always_comb begin
      lz        = clz48(prod_a_ff);
      norm_b_in = prod_a_ff << lz;
      exp_b_in  = exp_a_ff + 11'sd1 - $signed({5'd0, lz});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         norm_b_ff <= norm_b_in;
         exp_b_ff  <= exp_b_in;
         spc_b_ff  <= spc_a_ff;
         sgn_b_ff  <= sgn_a_ff;
      end
   end

   // stage C: shift into subnormal range if needed, then round
   logic signed [10:0] sh_full;
   logic [5:0]         sh;
   logic [95:0]        wide;
   logic [23:0]        m24;
   logic               guard, sticky, inc, is_norm;
   logic [7:0]         field;
   logic [30:0]        rnd;
   logic [31:0]        y_in, y_ff;

   always_comb begin
      is_norm = (exp_b_ff >= 11'sd1);
      sh_full = 11'sd1 - exp_b_ff;
      if (is_norm) begin
         sh = 6'd0;
      end else if (sh_full > 11'sd48) begin
         sh = 6'd48;
      end else begin
         sh = sh_full[5:0];
      end
      wide   = {norm_b_ff, 48'd0} >> sh;
      m24    = wide[95:72];
      guard  = wide[71];
      sticky = |wide[70:0];
      inc    = guard && (sticky || m24[0]);
      field  = is_norm ? exp_b_ff[7:0] : 8'd0;
      rnd    = {field, m24[22:0]} + {30'd0, inc};
      unique case (spc_b_ff)
         SPC_NAN:  y_in = FP_QNAN;
         SPC_INF:  y_in = {sgn_b_ff, FP_PINF[30:0]};
         SPC_ZERO: y_in = {sgn_b_ff, 31'd0};
         default: begin
            if (exp_b_ff >= 11'sd255) begin
               y_in = {sgn_b_ff, FP_PINF[30:0]};
            end else begin
               y_in = {sgn_b_ff, rnd};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

FILE: src/fep_add.sv
`timescale 1ns / 1ps
// Single-precision adder, round to nearest even, IEEE subnormals.
// Three stages: swap and align, add and count zeros, normalize and round. Uses fep_pkg.
module fep_add import fep_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);

   // stage A
   logic        swap;
   logic [31:0] big, sml;
   logic [7:0]  ebe, ese, d;
   logic [4:0]  dc;
   logic [23:0] mbg, msm;
   logic [53:0] al;
   logic        a_nan, b_nan, a_inf, b_inf;
   spc_type     spc_a_in, spc_a_ff;
   logic        sgn_a_in, sgn_a_ff, sub_a_ff;
   logic [7:0]  e_a_ff;
   logic [26:0] big_a_ff, sml_a_in, sml_a_ff;

   always_comb begin
      swap  = (b[30:0] > a[30:0]);
      big   = swap ? b : a;
      sml   = swap ? a : b;
      ebe   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      ese   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      mbg   = {|big[30:23], big[22:0]};
      msm   = {|sml[30:23], sml[22:0]};
      d     = ebe - ese;
      dc    = (d > 8'd27) ? 5'd27 : d[4:0];
      al    = {msm, 3'd0, 27'd0} >> dc;
      sml_a_in = {al[53:28], al[27] | (|al[26:0])};
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      sgn_a_in = big[31];
      priority if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
         spc_a_in = SPC_NAN;
      end else if (a_inf || b_inf) begin
         spc_a_in = SPC_INF;
         sgn_a_in = a_inf ? a[31] : b[31];
      end else begin
         spc_a_in = SPC_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spc_a_ff <= spc_a_in;
         sgn_a_ff <= sgn_a_in;
         sub_a_ff <= a[31] ^ b[31];
         e_a_ff   <= ebe;
         big_a_ff <= {mbg, 3'd0};
         sml_a_ff <= sml_a_in;
      end
   end

   // stage B
   logic [27:0] sum_b_in, sum_b_ff;
   logic        zero;
   logic [4:0]  lz_b_ff;
   logic [7:0]  e_b_ff;
   spc_type     spc_b_in, spc_b_ff;
   logic        sgn_b_in, sgn_b_ff;

   always_comb begin
      sum_b_in = sub_a_ff ? ({1'b0, big_a_ff} - {1'b0, sml_a_ff})
                          : ({1'b0, big_a_ff} + {1'b0, sml_a_ff});
      zero     = (sum_b_in == 28'd0);
      spc_b_in = ((spc_a_ff == SPC_NONE) && zero) ? SPC_ZERO : spc_a_ff;
      // exact cancellation gives +0
      sgn_b_in = (zero && sub_a_ff && (spc_a_ff == SPC_NONE)) ? 1'b0 : sgn_a_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_b_ff <= sum_b_in;
         lz_b_ff  <= clz28(sum_b_in);
         e_b_ff   <= e_a_ff;
         spc_b_ff <= spc_b_in;
         sgn_b_ff <= sgn_b_in;
      end
   end

   // stage C: shift is capped so the exponent does not drop below the subnormal floor
   logic signed [9:0] ex;
   logic              is_norm;
   logic [4:0]        s;
   logic [27:0]       nrm;
   logic [23:0]       m24;
   logic              inc;
   logic [7:0]        field;
   logic [30:0]       rnd;
   logic [31:0]       y_in, y_ff;

   always_comb begin
      ex      = $signed({2'd0, e_b_ff}) + 10'sd1 - $signed({5'd0, lz_b_ff});
      is_norm = (ex >= 10'sd1);
      s       = is_norm ? lz_b_ff : e_b_ff[4:0];
      nrm     = sum_b_ff << s;
      m24     = nrm[27:4];
      inc     = nrm[3] && ((|nrm[2:0]) || m24[0]);
      field   = is_norm ? ex[7:0] : 8'd0;
      rnd     = {field, m24[22:0]} + {30'd0, inc};
      unique case (spc_b_ff)
         SPC_NAN:  y_in = FP_QNAN;
         SPC_INF:  y_in = {sgn_b_ff, FP_PINF[30:0]};
         SPC_ZERO: y_in = {sgn_b_ff, 31'd0};
         default: begin
            if (ex >= 10'sd255) begin
               y_in = {sgn_b_ff, FP_PINF[30:0]};
            end else begin
               y_in = {sgn_b_ff, rnd};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

FILE: src/fast_exp_poly4.sv
`timescale 1ns / 1ps
// Top level of the single-precision e^x pipeline: range reduction, quartic, scale.
// Depends on fep_pkg, fep_mul, fep_add, fep_dly.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | req_tdata[31:0] = x_bits
//   rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata[31:0] = y_bits, rsp_tuser[0] = range_flag
//
// One item enters per cycle while no result waits untaken at rsp.
// From acceptance to rsp_tvalid the pipeline is made of 13 chained add/multiply
// units of 3 stages each plus the exponent extraction stage and the output register.
// Reset clears only the valid bits. A stall at rsp freezes every stage at once,
// so req_tready is low exactly while a result waits untaken.
module fast_exp_poly4 import fep_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] x_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] y_bits
   output logic [0:0]  rsp_tuser    // [0] range_flag
);

   logic                en;
   logic [PIPE_LAT-1:0] valid_ff;

   assign en         = !valid_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   // scaled = x * log2(e); t = scaled +/- 0.5
   logic [31:0] scaled, x3, half, t6, x6;

   fep_mul u_mul_scale (.clock, .en, .a(req_tdata), .b(FP_LOG2E), .y(scaled));
   fep_dly #(.W(32), .D(OP_LAT)) u_dly_x3 (.clock, .en, .d(req_tdata), .q(x3));

   // -0 counts as non-negative
   assign half = (x3[31] && (x3[30:0] != 31'd0)) ? FP_NHALF : FP_HALF;

   fep_add u_add_t (.clock, .en, .a(scaled), .b(half), .y(t6));
   fep_dly #(.W(32), .D(OP_LAT)) u_dly_x6 (.clock, .en, .d(x3), .q(x6));

   // n = trunc(t), nf = float(n), power of two built in the exponent field
   logic [23:0] tm;
   logic [7:0]  tsh;
   logic [23:0] tshift;
   logic [6:0]  mag, mnorm;
   logic [2:0]  mlz;
   logic        mhit;
   logic [7:0]  n_val, pw_exp;
   logic [31:0] nf_in, nf_ff;
   logic        is_nan, is_hi, is_lo;
   logic [34:0] side_in, side_ff, side37;
   logic [2:0]  side40;

   always_comb begin
      tm     = {1'b1, t6[22:0]};
      tsh    = 8'd150 - t6[30:23];
      tshift = tm >> tsh;
      mag    = (t6[30:23] < 8'd127) ? 7'd0 : tshift[6:0];
      n_val  = t6[31] ? (8'd0 - {1'b0, mag}) : {1'b0, mag};
      pw_exp = n_val + 8'd127;
      mlz    = 3'd0;
      mhit   = 1'b0;
      for (int i = 6; i >= 0; i--) begin
         if (!mhit && mag[i]) begin
            mlz  = 3'(6 - i);
            mhit = 1'b1;
         end
      end
      mnorm  = mag << mlz;
      if (mag == 7'd0) begin
         nf_in = FP_PZERO;
      end else begin
         nf_in = {t6[31], 8'd133 - {5'd0, mlz}, mnorm[5:0], 17'd0};
      end
      is_nan  = (x6[30:23] == 8'hFF) && (x6[22:0] != 23'd0);
      is_hi   = !t6[31] && (t6[30:0] >= 31'h43000000);  // t >= 128
      is_lo   = t6[31] && (t6[30:0] >= 31'h42FE0000);   // t <= -127
      side_in = {1'b0, pw_exp, 23'd0, is_nan, is_hi, is_lo};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nf_ff   <= nf_in;
         side_ff <= side_in;
      end
   end

   // red = x - n*ln2
   logic [31:0] prod, x10, red13, red19, red25, red31;

   fep_mul u_mul_prod (.clock, .en, .a(nf_ff), .b(FP_LN2), .y(prod));
   fep_dly #(.W(32), .D(OP_LAT + 1)) u_dly_x10 (.clock, .en, .d(x6), .q(x10));
   fep_add u_add_red (.clock, .en, .a(x10), .b({~prod[31], prod[30:0]}), .y(red13));

   fep_dly #(.W(32), .D(2 * OP_LAT)) u_dly_r19 (.clock, .en, .d(red13), .q(red19));
   fep_dly #(.W(32), .D(2 * OP_LAT)) u_dly_r25 (.clock, .en, .d(red19), .q(red25));
   fep_dly #(.W(32), .D(2 * OP_LAT)) u_dly_r31 (.clock, .en, .d(red25), .q(red31));

   // Horner quartic
   logic [31:0] h1, q1, h2, q2, h3, q3, mix, frac, yv;

   fep_mul u_mul_h1 (.clock, .en, .a(FP_CF4), .b(red13), .y(h1));
   fep_add u_add_q1 (.clock, .en, .a(h1), .b(FP_CF3), .y(q1));
   fep_mul u_mul_h2 (.clock, .en, .a(q1), .b(red19), .y(h2));
   fep_add u_add_q2 (.clock, .en, .a(h2), .b(FP_CF2), .y(q2));
   fep_mul u_mul_h3 (.clock, .en, .a(q2), .b(red25), .y(h3));
   fep_add u_add_q3 (.clock, .en, .a(h3), .b(FP_CF1), .y(q3));
   fep_mul u_mul_mix (.clock, .en, .a(red31), .b(q3), .y(mix));
   fep_add u_add_frac (.clock, .en, .a(FP_ONE), .b(mix), .y(frac));

   // power of two lines up with frac, the flags with the final product
   fep_dly #(.W(35), .D(10 * OP_LAT)) u_dly_side (.clock, .en, .d(side_ff), .q(side37));
   fep_dly #(.W(3), .D(OP_LAT)) u_dly_flags (.clock, .en, .d(side37[2:0]), .q(side40));

   fep_mul u_mul_y (.clock, .en, .a(side37[34:3]), .b(frac), .y(yv));

   // output register, special cases override the computed value
   logic [31:0] y_in, y_ff;
   logic        flag_in, flag_ff;

   always_comb begin
      flag_in = 1'b1;
      priority if (side40[2]) begin
         y_in = FP_QNAN;
      end else if (side40[1]) begin
         y_in = FP_PINF;
      end else if (side40[0]) begin
         y_in = FP_PZERO;
      end else begin
         y_in    = yv;
         flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff    <= y_in;
         flag_ff <= flag_in;
      end
   end

   assign rsp_tvalid   = valid_ff[PIPE_LAT-1];
   assign rsp_tdata    = y_ff;
   assign rsp_tuser[0] = flag_ff;

endmodule

FILE: src/fep_checker.sv
`timescale 1ns / 1ps
// Port-level checks for fast_exp_poly4, attached by bind.
// Depends on fast_exp_poly4 ports only.
module fep_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_rst_clear: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output stall");

   a_flag_val: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata == 32'h7FC00000) || (rsp_tdata == 32'h7F800000) ||
         (rsp_tdata == 32'h00000000))
      else $error("flagged item carries a computed value");

   a_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tdata[31] && (rsp_tdata[30:23] != 8'hFF))
      else $error("in-range item is negative or non-finite");

endmodule

bind fast_exp_poly4 fep_checker u_fep_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: bench/fep_checker.sv
`timescale 1ns / 1ps
// Watches both channels of fast_exp_poly4, predicts e^x per accepted item with a
// bit-exact single-precision model and compares results in order. Depends on fep_pkg.
module fep_scoreboard import fep_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [31:0] y;
      logic        flag;
   } exp_result_type;

   exp_result_type exp_queue[$];

   // value = sig * 2^(e - 153); normalize, round to nearest even, pack
   function automatic logic [31:0] sp_round(input logic s, input int e, input logic [63:0] sig);
      int          p;
      int          sh;
      logic        sticky;
      logic [63:0] mant;
      if (sig == 0) return {s, 31'd0};
      p = 0;
      for (int i = 0; i < 64; i++) if (sig[i]) p = i;
      if (p > 26) begin
         sh = p - 26;
         sticky = |(sig & ((64'd1 << sh) - 64'd1));
         sig = (sig >> sh) | {63'd0, sticky};
         e = e + sh;
      end else begin
         sig = sig << (26 - p);
         e = e - (26 - p);
      end
      if (e < 1) begin
         sh = 1 - e;
         if (sh > 40) sig = 64'd1;
         else begin
            sticky = |(sig & ((64'd1 << sh) - 64'd1));
            sig = (sig >> sh) | {63'd0, sticky};
         end
         e = 1;
      end
      mant = sig >> 3;
      if (sig[2] && ((|sig[1:0]) || mant[0])) mant = mant + 64'd1;
      if (mant[24]) begin
         mant = mant >> 1;
         e = e + 1;
      end
      if (e >= 255) return {s, 8'hFF, 23'd0};
      if (!mant[23]) return {s, 8'd0, mant[22:0]};
      return {s, e[7:0], mant[22:0]};
   endfunction

   function automatic void sp_split(input logic [31:0] a, output int e, output logic [63:0] m);
      e = (a[30:23] == 0) ? 1 : int'(a[30:23]);
      m = {40'd0, (a[30:23] != 0), a[22:0]};
   endfunction

   function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
      int          ea;
      int          eb;
      logic [63:0] ma;
      logic [63:0] mb;
      logic        s;
      s = a[31] ^ b[31];
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {s, 8'hFF, 23'd0};
      sp_split(a, ea, ma);
      sp_split(b, eb, mb);
      return sp_round(s, ea + eb - 147, ma * mb);
   endfunction

   function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
      int          ea;
      int          eb;
      int          d;
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] sum;
      logic [31:0] tmp;
      logic        sticky;
      if (a[30:23] == 8'hFF) return a;
      if (b[30:23] == 8'hFF) return b;
      if (b[30:0] > a[30:0]) begin
         tmp = a;
         a = b;
         b = tmp;
      end
      sp_split(a, ea, ma);
      sp_split(b, eb, mb);
      ma = ma << 3;
      mb = mb << 3;
      d = ea - eb;
      if (d > 40) mb = {63'd0, mb != 0};
      else begin
         sticky = |(mb & ((64'd1 << d) - 64'd1));
         mb = (mb >> d) | {63'd0, sticky};
      end
      sum = (a[31] == b[31]) ? ma + mb : ma - mb;
      if (sum == 0) return {a[31] & b[31], 31'd0};
      return sp_round(a[31], ea, sum);
   endfunction

   function automatic exp_result_type predict_exp(input logic [31:0] x);
      exp_result_type r;
      logic [31:0]    t;
      logic [31:0]    red;
      logic [31:0]    q;
      logic [31:0]    nmag;
      int             n;
      r.flag = 1'b1;
      if (x[30:23] == 8'hFF && x[22:0] != 0) begin
         r.y = FP_QNAN;
         return r;
      end
      // negative zero takes the +0.5 offset
      t = sp_add(sp_mul(x, FP_LOG2E), (!x[31] || x[30:0] == 0) ? FP_HALF : FP_NHALF);
      if (!t[31] && t[30:0] >= 31'h43000000) begin
         r.y = FP_PINF;
         return r;
      end
      if (t[31] && t[30:0] >= 31'h42FE0000) begin
         r.y = FP_PZERO;
         return r;
      end
      if (t[30:23] < 8'd127) nmag = 0;
      else nmag = {8'd1, t[22:0]} >> (150 - int'(t[30:23]));
      n = t[31] ? -int'(nmag) : int'(nmag);
      red = sp_add(x, sp_mul(sp_round(t[31], 153, {32'd0, nmag}), FP_LN2) ^ 32'h80000000);
      q = sp_add(sp_mul(FP_CF4, red), FP_CF3);
      q = sp_add(sp_mul(q, red), FP_CF2);
      q = sp_add(sp_mul(q, red), FP_CF1);
      q = sp_add(FP_ONE, sp_mul(red, q));
      r.y = sp_mul({1'b0, 8'(n + 127), 23'd0}, q);
      r.flag = 1'b0;
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      exp_result_type e;
      if (!reset) begin
         if (req_tvalid && req_tready) exp_queue.push_back(predict_exp(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (exp_queue.size() == 0) begin
               $display("%0t: unexpected item y=%h flag=%b", $time, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               e = exp_queue.pop_front();
               if (e.y !== rsp_tdata || e.flag !== rsp_tuser[0]) begin
                  $display("%0t: mismatch expected y=%h flag=%b actual y=%h flag=%b",
                           $time, e.y, e.flag, rsp_tdata, rsp_tuser);
                  fail_count++;
               end
            end
         end
         pending = exp_queue.size();
      end
   end

endmodule

FILE: bench/tb_fast_exp_poly4.sv
`timescale 1ns / 1ps
// Stimulus and verdict for fast_exp_poly4: directed and random x values, random
// idling on both channels. Depends on fep_pkg, fast_exp_poly4 and fep_scoreboard.
module tb_fast_exp_poly4 import fep_pkg::*;;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   int          fail_count;
   int          pending;
   logic        calm;
   logic        hold_off;

   localparam int RANDOM_ITEMS = 1730;

   fast_exp_poly4 dut (.*);

   fep_scoreboard u_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_x(input logic [31:0] x);
      req_tdata = x;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic maybe_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] random_x();
      // mostly in-range arguments with random mantissa, some raw patterns
      if ($urandom_range(0, 4) == 0) return $urandom;
      return {1'(($urandom)), 8'($urandom_range(100, 133)), 23'($urandom)};
   endfunction

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready = 1'b0;
            repeat (200) @(negedge clock);
            hold_off = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      logic [31:0] directed[$];
      req_tvalid = 1'b0;
      req_tdata = '0;
      calm = 1'b0;
      hold_off = 1'b0;
      reset = 1'b1;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      directed = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
                   32'h7F800001, 32'hFFFFFFFF, 32'h3F800000, 32'hBF800000, 32'h7F7FFFFF,
                   32'hFF7FFFFF, 32'h00000001, 32'h80000001, 32'h007FFFFF, 32'h42B17218,
                   32'h42B17217, 32'h42B20000, 32'hC2AEAC50, 32'hC2B00000, 32'hC2CE0000,
                   32'hC2CF0000, 32'h3EB17218, 32'hBEB17218, 32'h42FE0000};
      foreach (directed[i]) begin
         send_x(directed[i]);
         maybe_gap();
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300) hold_off = 1'b1;
         if (i == 800) begin
            req_tvalid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         if (i == RANDOM_ITEMS - 200) calm = 1'b1;
         send_x(random_x());
         maybe_gap();
      end
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
